@@ sv/cet_pkg.sv @@
// Shared types and constants for the 3x3 compass edge threshold block.
`timescale 1ns / 1ps
package cet_pkg;

    localparam int PIX_W  = 8;
    localparam int RESP_W = 11;
    localparam int THR_W  = 10;
    localparam int IW_W   = 11;
    localparam int IH_W   = 13;
    localparam int APB_AW = 4;
    localparam int APB_DW = 32;

    typedef logic [PIX_W-1:0] t_pixel;
    typedef logic signed [RESP_W-1:0] t_resp;

    typedef struct packed {
        t_resp k3;
        t_resp k2;
        t_resp k1;
        t_resp k0;
    } t_resp_set;

    typedef struct packed {
        t_pixel upper;
        t_pixel middle;
    } t_line_pair;

    typedef struct packed {
        logic [THR_W-1:0] threshold;
        logic [IW_W-1:0]  image_width;
        logic [IH_W-1:0]  image_height;
    } t_cfg;

    typedef enum logic [1:0] {
        REG_THRESHOLD    = 2'd0,
        REG_IMAGE_WIDTH  = 2'd1,
        REG_IMAGE_HEIGHT = 2'd2,
        REG_UNUSED       = 2'd3
    } t_reg_idx;

    localparam logic [THR_W-1:0] THRESHOLD_RST    = THR_W'(100);
    localparam logic [IW_W-1:0]  IMAGE_WIDTH_RST  = IW_W'(640);
    localparam logic [IH_W-1:0]  IMAGE_HEIGHT_RST = IH_W'(480);

    localparam t_pixel EDGE_ON  = 8'd0;
    localparam t_pixel EDGE_OFF = 8'd255;

endpackage

@@ sv/compass_edge_threshold_3x3_core.sv @@
// Top level of the streaming 3x3 compass edge detector with threshold.
`timescale 1ns / 1ps
// Usage:
//   Slave stream: one 8-bit grey pixel per item in raster order, tdata[7:0].
//   Master stream: one item per interior pixel; tdata[7:0] is 0 for an edge,
//   255 otherwise, tlast marks the last interior result of the frame.
//   Border pixels (first two lines, first two columns) give no output item.
//   APB port: threshold at 0x0, image_width at 0x4, image_height at 0x8;
//   sizes outside 3..MAX_WIDTH / 3..MAX_HEIGHT are clamped. Write only while idle.
// Timing:
//   One pixel per cycle sustained while the master port is ready. The result for
//   centre (r-1, c-1) reaches the master port through the line store read,
//   the window and kernel stage, and the threshold and output register.
//   The line store is a single read-modify-write memory; a column is read on
//   acceptance and written back one stage later, so no same-entry overlap.
// Reset:
//   Counters, window and valid flags clear; registers take their defaults.
//   Line store contents stay undefined until the first two lines fill them.
// Backpressure:
//   When o_m_axis_tvalid is held off by i_m_axis_tready low, stages fill and
//   o_s_axis_tready drops once all three are occupied; nothing is lost.
module compass_edge_threshold_3x3_core #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_s_axis_tvalid,
    output logic                        o_s_axis_tready,
    input  logic [7:0]                  i_s_axis_tdata,   // [7:0] pixel_in
    output logic                        o_m_axis_tvalid,
    input  logic                        i_m_axis_tready,
    output logic [7:0]                  o_m_axis_tdata,   // [7:0] edge_value
    output logic                        o_m_axis_tlast,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [cet_pkg::APB_AW-1:0]  paddr,
    input  logic [cet_pkg::APB_DW-1:0]  pwdata,
    output logic [cet_pkg::APB_DW-1:0]  prdata,
    output logic                        pready
);
    import cet_pkg::*;

    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int ROW_W = $clog2(MAX_HEIGHT);
    localparam int WCMP  = (COL_W + 1 > IW_W) ? COL_W + 1 : IW_W;
    localparam int HCMP  = (ROW_W + 1 > IH_W) ? ROW_W + 1 : IH_W;

    t_cfg w_cfg;

    logic [WCMP-1:0]  w_w_ext;
    logic [WCMP-1:0]  w_w_clamp;
    logic [COL_W:0]   w_eff_w;
    logic [HCMP-1:0]  w_h_ext;
    logic [HCMP-1:0]  w_h_clamp;
    logic [ROW_W:0]   w_eff_h;

    logic [COL_W-1:0] r_col;
    logic [ROW_W-1:0] r_row;
    logic [COL_W:0]   w_col_next;
    logic [ROW_W:0]   w_row_next;
    logic             w_line_end;
    logic             w_frame_end;
    logic             w_produce;

    logic             w_accept;
    logic             w_s1_adv;
    logic             w_s1_free;
    logic             w_s2_adv;
    logic             w_s2_free;
    logic             w_out_free;

    logic             r_s1_valid;
    t_pixel           r_s1_pixel;
    logic [COL_W-1:0] r_s1_col;
    logic             r_s1_produce;
    logic             r_s1_last;

    logic             r_s2_valid;
    logic             r_s2_last;

    logic             r_out_valid;
    t_pixel           r_out_edge;
    logic             r_out_last;

    t_line_pair       w_rd_data;
    t_line_pair       w_wr_data;
    t_resp_set        w_resp;
    t_resp            w_thr;
    logic             w_edge;

    cet_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    always_comb begin
        w_w_ext = WCMP'(w_cfg.image_width);
        if (w_w_ext < WCMP'(3)) begin
            w_w_clamp = WCMP'(3);
        end else if (w_w_ext > WCMP'(MAX_WIDTH)) begin
            w_w_clamp = WCMP'(MAX_WIDTH);
        end else begin
            w_w_clamp = w_w_ext;
        end
        w_eff_w = w_w_clamp[COL_W:0];

        w_h_ext = HCMP'(w_cfg.image_height);
        if (w_h_ext < HCMP'(3)) begin
            w_h_clamp = HCMP'(3);
        end else if (w_h_ext > HCMP'(MAX_HEIGHT)) begin
            w_h_clamp = HCMP'(MAX_HEIGHT);
        end else begin
            w_h_clamp = w_h_ext;
        end
        w_eff_h = w_h_clamp[ROW_W:0];
    end

    assign w_col_next  = {1'b0, r_col} + (COL_W + 1)'(1);
    assign w_row_next  = {1'b0, r_row} + (ROW_W + 1)'(1);
    assign w_line_end  = (w_col_next >= w_eff_w);
    assign w_frame_end = w_line_end && (w_row_next >= w_eff_h);
    assign w_produce   = (r_row >= ROW_W'(2)) && (r_col >= COL_W'(2));

    assign w_out_free      = !r_out_valid || i_m_axis_tready;
    assign w_s2_adv        = r_s2_valid && w_out_free;
    assign w_s2_free       = !r_s2_valid || w_out_free;
    assign w_s1_adv        = r_s1_valid && w_s2_free;
    assign w_s1_free       = !r_s1_valid || w_s2_free;
    assign o_s_axis_tready = w_s1_free;
    assign w_accept        = i_s_axis_tvalid && w_s1_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (w_accept) begin
            if (w_line_end) begin
                r_col <= '0;
                r_row <= w_frame_end ? '0 : w_row_next[ROW_W-1:0];
            end else begin
                r_col <= w_col_next[COL_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_accept) begin
            r_s1_valid <= 1'b1;
        end else if (w_s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1_pixel   <= i_s_axis_tdata;
            r_s1_col     <= r_col;
            r_s1_produce <= w_produce;
            r_s1_last    <= w_frame_end;
        end
    end

    assign w_wr_data.upper  = w_rd_data.middle;
    assign w_wr_data.middle = r_s1_pixel;

    cet_line_store #(
        .DEPTH  (MAX_WIDTH),
        .ADDR_W (COL_W)
    ) u_line_store (
        .i_clk     (i_clk),
        .i_rd_en   (w_accept),
        .i_rd_addr (r_col),
        .o_rd_data (w_rd_data),
        .i_wr_en   (w_s1_adv),
        .i_wr_addr (r_s1_col),
        .i_wr_data (w_wr_data)
    );

    cet_window u_window (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_shift (w_s1_adv),
        .i_top   (w_rd_data.upper),
        .i_mid   (w_rd_data.middle),
        .i_pix   (r_s1_pixel),
        .o_resp  (w_resp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (w_s1_adv) begin
            r_s2_valid <= r_s1_produce;
        end else if (w_s2_adv) begin
            r_s2_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s1_adv) begin
            r_s2_last <= r_s1_last;
        end
    end

    assign w_thr  = $signed({1'b0, w_cfg.threshold});
    assign w_edge = (w_resp.k0 > w_thr) || (w_resp.k1 > w_thr)
                 || (w_resp.k2 > w_thr) || (w_resp.k3 > w_thr);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_s2_adv) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s2_adv) begin
            r_out_edge <= w_edge ? EDGE_ON : EDGE_OFF;
            r_out_last <= r_s2_last;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_edge;
    assign o_m_axis_tlast  = r_out_last;

endmodule

@@ sv/cet_cfg_regs.sv @@
// Configuration register file behind the APB-style port.
`timescale 1ns / 1ps
module cet_cfg_regs (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [cet_pkg::APB_AW-1:0]  paddr,
    input  logic [cet_pkg::APB_DW-1:0]  pwdata,
    output logic [cet_pkg::APB_DW-1:0]  prdata,
    output logic                        pready,
    output cet_pkg::t_cfg               o_cfg
);
    import cet_pkg::*;

    t_cfg     r_cfg;
    t_reg_idx w_idx;
    logic     w_wr;

    assign pready = 1'b1;
    assign w_idx  = t_reg_idx'(paddr[APB_AW-1:2]);
    assign w_wr   = psel && penable && pwrite;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.threshold    <= THRESHOLD_RST;
            r_cfg.image_width  <= IMAGE_WIDTH_RST;
            r_cfg.image_height <= IMAGE_HEIGHT_RST;
        end else if (w_wr) begin
            unique case (w_idx)
                REG_THRESHOLD:    r_cfg.threshold    <= pwdata[THR_W-1:0];
                REG_IMAGE_WIDTH:  r_cfg.image_width  <= pwdata[IW_W-1:0];
                REG_IMAGE_HEIGHT: r_cfg.image_height <= pwdata[IH_W-1:0];
                REG_UNUSED:       ;
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            REG_THRESHOLD:    prdata = APB_DW'(r_cfg.threshold);
            REG_IMAGE_WIDTH:  prdata = APB_DW'(r_cfg.image_width);
            REG_IMAGE_HEIGHT: prdata = APB_DW'(r_cfg.image_height);
            REG_UNUSED:       prdata = '0;
        endcase
    end

endmodule

@@ sv/cet_line_store.sv @@
// Dual line store: one synchronous memory holding the two previous lines per column.
`timescale 1ns / 1ps
module cet_line_store #(
    parameter int DEPTH  = 1024,
    parameter int ADDR_W = 10
) (
    input  logic                 i_clk,
    input  logic                 i_rd_en,
    input  logic [ADDR_W-1:0]    i_rd_addr,
    output cet_pkg::t_line_pair  o_rd_data,
    input  logic                 i_wr_en,
    input  logic [ADDR_W-1:0]    i_wr_addr,
    input  cet_pkg::t_line_pair  i_wr_data
);
    import cet_pkg::*;

    t_line_pair r_mem [DEPTH];
    t_line_pair r_rd_data;

    assign o_rd_data = r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

@@ sv/cet_window.sv @@
// 3x3 window register and the four compass kernel responses.
`timescale 1ns / 1ps
module cet_window (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_shift,
    input  cet_pkg::t_pixel     i_top,
    input  cet_pkg::t_pixel     i_mid,
    input  cet_pkg::t_pixel     i_pix,
    output cet_pkg::t_resp_set  o_resp
);
    import cet_pkg::*;

    t_pixel    r_win [3][3];
    t_pixel    n_win [3][3];
    t_resp     w_t [3][3];
    t_resp_set n_resp;
    t_resp_set r_resp;

    assign o_resp = r_resp;

    always_comb begin
        for (int r = 0; r < 3; r++) begin
            n_win[r][0] = r_win[r][1];
            n_win[r][1] = r_win[r][2];
        end
        n_win[0][2] = i_top;
        n_win[1][2] = i_mid;
        n_win[2][2] = i_pix;
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
                w_t[r][c] = $signed({{(RESP_W-PIX_W){1'b0}}, n_win[r][c]});
            end
        end
    end

    always_comb begin
        n_resp.k0 = w_t[0][2] - w_t[0][0] + ((w_t[1][2] - w_t[1][0]) <<< 1)
                  + w_t[2][2] - w_t[2][0];
        n_resp.k1 = w_t[2][0] - w_t[0][0] + ((w_t[2][1] - w_t[0][1]) <<< 1)
                  + w_t[2][2] - w_t[0][2];
        n_resp.k2 = w_t[0][0] + w_t[0][1] + w_t[1][0]
                  - w_t[1][2] - w_t[2][1] - w_t[2][2];
        n_resp.k3 = w_t[0][1] + w_t[0][2] + w_t[1][2]
                  - w_t[1][0] - w_t[2][0] - w_t[2][1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int r = 0; r < 3; r++) begin
                for (int c = 0; c < 3; c++) begin
                    r_win[r][c] <= '0;
                end
            end
        end else if (i_shift) begin
            r_win <= n_win;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_resp <= n_resp;
        end
    end

endmodule

@@ verif/compass_edge_threshold_3x3_core_test.sv @@
// Self-checking stream testbench for the 3x3 compass edge threshold core.
`timescale 1ns / 1ps
module compass_edge_threshold_3x3_core_test;
    import cet_pkg::*;

    localparam int FRAME_MAX_W = 1024;
    localparam int FRAME_MAX_H = 4096;
    localparam int PIPE_SETTLE = 8;
    localparam int HOLD_AT_PIXEL = 700;
    localparam int HOLD_CYCLES = 200;

    localparam int PIX_NOISE  = 0;
    localparam int PIX_SMOOTH = 1;
    localparam int PIX_BINARY = 2;

    localparam int RX_OPEN   = 0;
    localparam int RX_COIN   = 1;
    localparam int RX_SPARSE = 2;
    localparam int RX_TOGGLE = 3;

    typedef struct packed {
        t_pixel edge_value;
        logic   frame_last;
    } t_edge_item;

    typedef struct packed {
        t_pixel px;
        logic   typed;
        t_pixel edge_value;
        logic   frame_last;
    } t_probe_row;

    logic              i_clk;
    logic              i_rst_n = 1'b0;
    logic              i_s_axis_tvalid = 1'b0;
    logic              o_s_axis_tready;
    logic [7:0]        i_s_axis_tdata = '0;
    logic              o_m_axis_tvalid;
    logic              i_m_axis_tready = 1'b0;
    logic [7:0]        o_m_axis_tdata;
    logic              o_m_axis_tlast;
    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [APB_AW-1:0] paddr = '0;
    logic [APB_DW-1:0] pwdata = '0;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    compass_edge_threshold_3x3_core u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    // Model state of the edge detector
    logic [THR_W-1:0] thr_q = THRESHOLD_RST;
    logic [IW_W-1:0]  wid_q = IMAGE_WIDTH_RST;
    logic [IH_W-1:0]  hgt_q = IMAGE_HEIGHT_RST;
    int               upper_line [FRAME_MAX_W];
    int               middle_line [FRAME_MAX_W];
    int               win [3][3];
    int               col_pos = 0;
    int               row_pos = 0;

    t_edge_item pending_edges [$];
    int         fail_count = 0;
    int         pixels_sent = 0;
    int         burst_left = 0;

    // Frame of 5x5: flat zeros, a threshold probe at 100 / 101, then a bright band
    t_probe_row probe_rows [25] = '{
        '{8'd0,   1'b0, 8'd0,     1'b0},
        '{8'd0,   1'b0, 8'd0,     1'b0},
        '{8'd0,   1'b0, 8'd0,     1'b0},
        '{8'd0,   1'b0, 8'd0,     1'b0},
        '{8'd0,   1'b0, 8'd0,     1'b0},
        '{8'd0,   1'b0, 8'd0,     1'b0},
        '{8'd0,   1'b0, 8'd0,     1'b0},
        '{8'd0,   1'b0, 8'd0,     1'b0},
        '{8'd0,   1'b0, 8'd0,     1'b0},
        '{8'd0,   1'b0, 8'd0,     1'b0},
        '{8'd0,   1'b0, 8'd0,     1'b0},
        '{8'd0,   1'b0, 8'd0,     1'b0},
        '{8'd0,   1'b1, EDGE_OFF, 1'b0},
        '{8'd100, 1'b1, EDGE_OFF, 1'b0},
        '{8'd101, 1'b0, 8'd0,     1'b0},
        '{8'd255, 1'b0, 8'd0,     1'b0},
        '{8'd255, 1'b0, 8'd0,     1'b0},
        '{8'd255, 1'b0, 8'd0,     1'b0},
        '{8'd255, 1'b0, 8'd0,     1'b0},
        '{8'd255, 1'b0, 8'd0,     1'b0},
        '{8'd255, 1'b0, 8'd0,     1'b0},
        '{8'd255, 1'b0, 8'd0,     1'b0},
        '{8'd255, 1'b0, 8'd0,     1'b0},
        '{8'd255, 1'b0, 8'd0,     1'b0},
        '{8'd255, 1'b1, EDGE_ON,  1'b1}
    };

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #(50_000_000);
        $display("FAIL");
        $finish;
    end

    function automatic void compass_predict(input t_pixel px, output logic hit,
                                            output t_edge_item item);
        int w_eff;
        int h_eff;
        int top;
        int mid;
        int gx;
        int gy;
        int d1;
        int d2;
        int best;
        logic line_end;
        logic frame_end;
        w_eff = (wid_q < 3) ? 3 : (wid_q > FRAME_MAX_W) ? FRAME_MAX_W : int'(wid_q);
        h_eff = (hgt_q < 3) ? 3 : (hgt_q > FRAME_MAX_H) ? FRAME_MAX_H : int'(hgt_q);
        top = upper_line[col_pos];
        mid = middle_line[col_pos];
        upper_line[col_pos] = mid;
        middle_line[col_pos] = int'(px);
        for (int r = 0; r < 3; r++) begin
            win[r][0] = win[r][1];
            win[r][1] = win[r][2];
        end
        win[0][2] = top;
        win[1][2] = mid;
        win[2][2] = int'(px);
        line_end = (col_pos + 1 >= w_eff);
        frame_end = line_end && (row_pos + 1 >= h_eff);
        hit = (row_pos >= 2) && (col_pos >= 2);
        gx = (win[0][2] + 2 * win[1][2] + win[2][2]) - (win[0][0] + 2 * win[1][0] + win[2][0]);
        gy = (win[2][0] + 2 * win[2][1] + win[2][2]) - (win[0][0] + 2 * win[0][1] + win[0][2]);
        d1 = win[0][0] + win[0][1] + win[1][0] - win[1][2] - win[2][1] - win[2][2];
        d2 = win[0][1] + win[0][2] + win[1][2] - win[1][0] - win[2][0] - win[2][1];
        best = gx;
        if (gy > best) best = gy;
        if (d1 > best) best = d1;
        if (d2 > best) best = d2;
        item.edge_value = (best > int'(thr_q)) ? EDGE_ON : EDGE_OFF;
        item.frame_last = frame_end;
        if (line_end) begin
            col_pos = 0;
            row_pos = frame_end ? 0 : row_pos + 1;
        end else begin
            col_pos = col_pos + 1;
        end
    endfunction

    function automatic t_pixel make_pixel(input int style, input int base);
        int v;
        case (style)
            PIX_SMOOTH: begin
                v = base + int'($urandom_range(0, 48)) - 24;
                if (v < 0) v = 0;
                if (v > 255) v = 255;
            end
            PIX_BINARY: v = ($urandom_range(0, 1) == 1) ? 255 : 0;
            default: v = int'($urandom_range(0, 255));
        endcase
        return t_pixel'(v);
    endfunction

    task automatic reg_write(input t_reg_idx idx, input logic [APB_DW-1:0] val);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        case (idx)
            REG_THRESHOLD:    thr_q = val[THR_W-1:0];
            REG_IMAGE_WIDTH:  wid_q = val[IW_W-1:0];
            REG_IMAGE_HEIGHT: hgt_q = val[IH_W-1:0];
            default: ;
        endcase
        // read back through the same select
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata !== val) begin
            $error("%s readback: expected %0d, got %0d", idx.name(), val, prdata);
            fail_count++;
        end
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_frame(input int th, input int w, input int h);
        reg_write(REG_THRESHOLD, APB_DW'(th));
        reg_write(REG_IMAGE_WIDTH, APB_DW'(w));
        reg_write(REG_IMAGE_HEIGHT, APB_DW'(h));
    endtask

    task automatic feed_pixel(input t_pixel px, output logic hit, output t_edge_item item);
        if (burst_left == 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(60, 250)
                                                     : $urandom_range(1, 24);
        end
        burst_left--;
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata <= px;
        do @(posedge i_clk); while (!o_s_axis_tready);
        pixels_sent++;
        compass_predict(px, hit, item);
    endtask

    task automatic drain();
        i_s_axis_tvalid <= 1'b0;
        burst_left = 0;
        while (pending_edges.size() != 0) @(posedge i_clk);
        repeat (PIPE_SETTLE) @(posedge i_clk);
    endtask

    task automatic feed(input int count, input int style);
        int base;
        logic hit;
        t_edge_item item;
        base = int'($urandom_range(0, 255));
        for (int i = 0; i < count; i++) begin
            feed_pixel(make_pixel(style, base), hit, item);
            if (hit) pending_edges.push_back(item);
        end
        drain();
    endtask

    // Output side: stall pattern with one long hold-off mid-run
    int rx_mode = RX_OPEN;
    int rx_left = 0;
    int hold_left = 0;
    bit hold_done = 1'b0;

    always @(posedge i_clk) begin
        if (!hold_done && pixels_sent >= HOLD_AT_PIXEL) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_m_axis_tready <= 1'b0;
        end else begin
            if (rx_left == 0) begin
                rx_mode = $urandom_range(RX_OPEN, RX_TOGGLE);
                rx_left = $urandom_range(20, 120);
            end
            rx_left--;
            case (rx_mode)
                RX_OPEN:   i_m_axis_tready <= 1'b1;
                RX_COIN:   i_m_axis_tready <= ($urandom_range(0, 1) == 1);
                RX_SPARSE: i_m_axis_tready <= ($urandom_range(0, 3) == 0);
                default:   i_m_axis_tready <= ~i_m_axis_tready;
            endcase
        end
    end

    always @(posedge i_clk) begin : check_out
        t_edge_item want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (pending_edges.size() == 0) begin
                $error("result item with nothing expected: edge_value %0d", o_m_axis_tdata);
                fail_count++;
            end else begin
                want = pending_edges.pop_front();
                if (o_m_axis_tdata !== want.edge_value) begin
                    $error("edge_value: expected %0d, got %0d", want.edge_value, o_m_axis_tdata);
                    fail_count++;
                end
                if (o_m_axis_tlast !== want.frame_last) begin
                    $error("frame_last: expected %0d, got %0d", want.frame_last, o_m_axis_tlast);
                    fail_count++;
                end
            end
        end
    end

    initial begin : stimulus
        int rand_items;
        int th;
        int w;
        int h;
        int frames;
        logic hit;
        t_edge_item got;
        rand_items = 0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed frame, threshold left at its reset value
        reg_write(REG_IMAGE_WIDTH, APB_DW'(5));
        reg_write(REG_IMAGE_HEIGHT, APB_DW'(5));
        for (int i = 0; i < 25; i++) begin
            feed_pixel(probe_rows[i].px, hit, got);
            if (hit) begin
                if (probe_rows[i].typed)
                    got = {probe_rows[i].edge_value, probe_rows[i].frame_last};
                pending_edges.push_back(got);
            end
        end
        drain();

        // Register extremes: sizes below 3 clamp up to 3x3, threshold at both ends
        set_frame(0, 0, 0);
        feed(10 * 9, PIX_BINARY);
        set_frame(1023, 7, 6);
        feed(2 * 7 * 6, PIX_NOISE);

        // Height shrunk mid-frame ends the frame at the current line
        set_frame($urandom_range(0, 400), 4, 8191);
        feed(20, PIX_NOISE);
        set_frame($urandom_range(0, 400), 4, 0);
        feed(4 + 5 * 12, PIX_BINARY);

        // Width shrunk mid-line ends the line at once
        set_frame($urandom_range(0, 400), 12, 5);
        feed(30, PIX_SMOOTH);
        set_frame($urandom_range(0, 400), 4, 5);
        feed(9 + 2 * 20, PIX_NOISE);

        while (rand_items < 790) begin
            case ($urandom_range(0, 7))
                0: th = 0;
                1: th = 1023;
                default: th = $urandom_range(0, 400);
            endcase
            w = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 80) : $urandom_range(3, 16);
            h = $urandom_range(3, 6);
            frames = $urandom_range(1, 2);
            set_frame(th, w, h);
            feed(frames * w * h, $urandom_range(PIX_NOISE, PIX_BINARY));
            rand_items += frames * w * h;
        end

        if (fail_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
